[rtl/mshr_table_with_merge_queues_unit_assert.svh]
`ifndef MSHR_TABLE_WITH_MERGE_QUEUES_UNIT_ASSERT_SVH
`define MSHR_TABLE_WITH_MERGE_QUEUES_UNIT_ASSERT_SVH
// Assertion macros shared by the checker.
`define MSHR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MSHR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/mshr_pkg.sv]
package mshr_pkg;
  localparam int unsigned Entries = 8;
  localparam int unsigned Slots = 4;
  localparam int unsigned TagWidth = 20;
  localparam int unsigned SetWidth = 12;
  localparam int unsigned EW = $clog2(Entries);
  localparam int unsigned SW = $clog2(Slots);
  localparam int unsigned QDepth = 2;

  localparam logic [2:0] CmdRequest = 3'd0;
  localparam logic [2:0] CmdIssue = 3'd1;
  localparam logic [2:0] CmdTick = 3'd2;
  localparam logic [2:0] CmdRetire = 3'd3;
  localparam logic [2:0] CmdLookup = 3'd4;

  localparam logic [1:0] StAlloc = 2'd0;
  localparam logic [1:0] StMerged = 2'd1;
  localparam logic [1:0] StTableFull = 2'd2;
  localparam logic [1:0] StSlotsFull = 2'd3;
  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StNothing = 2'd1;

  localparam logic [1:0] RegLatency = 2'd0;
  localparam logic [1:0] RegEntries = 2'd1;
  localparam logic [1:0] RegSlots = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [47:0] miss_addr;
    logic [19:0] line_tag;
    logic [11:0] set_number;
    logic [1:0] access_kind;
    logic [15:0] request_id;
    logic [2:0] entry_select;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] entry_index;
    logic [1:0] slot_index;
    logic [47:0] issue_addr;
    logic [1:0] retired_kind;
    logic [15:0] retired_id;
    logic entry_freed;
    logic lookup_hit;
  } out_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [2:0] cmd;
    logic hit;
    logic [EW-1:0] hit_idx;
    logic [47:0] miss_addr;
    logic [TagWidth-1:0] tag;
    logic [SetWidth-1:0] set;
    logic [1:0] kind;
    logic [15:0] rid;
    logic [2:0] sel;
  } job_t;
endpackage

[rtl/mshr_front.sv]
module mshr_front import mshr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t in_i,
  input  logic [Entries-1:0] valid_i,
  input  logic [Entries-1:0] live_i,
  input  logic [TagWidth-1:0] tag_i [Entries],
  input  logic [SetWidth-1:0] set_i [Entries],
  input  logic q_full_i,
  output logic busy_o,
  output logic push_o,
  output job_t job_o
);
  logic pend_q, pend_d;
  in_t item_q;
  logic hit;
  logic [EW-1:0] hidx;

  assign busy_o = pend_q || q_full_i;

  always_comb begin
    hit = 1'b0;
    hidx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (live_i[i] && valid_i[i] && tag_i[i] == item_q.line_tag[TagWidth-1:0]
          && set_i[i] == item_q.set_number[SetWidth-1:0]) begin
        hit = 1'b1;
        hidx = EW'(i);
      end
    end
  end

  assign push_o = pend_q;
  assign job_o = '{cmd: item_q.cmd, hit: hit, hit_idx: hidx, miss_addr: item_q.miss_addr,
                   tag: item_q.line_tag[TagWidth-1:0], set: item_q.set_number[SetWidth-1:0],
                   kind: item_q.access_kind, rid: item_q.request_id,
                   sel: item_q.entry_select};

  always_comb begin
    pend_d = 1'b0;
    if (start_i && !busy_o) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      item_q <= in_i;
    end
  end
endmodule

[rtl/mshr_queue.sv]
module mshr_queue import mshr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output logic empty_o,
  output logic full_o,
  output job_t data_o
);
  localparam int unsigned PW = $clog2(QDepth);
  job_t mem_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0] cnt_q;

  assign empty_o = cnt_q == '0;
  assign full_o = cnt_q != '0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end
endmodule

[rtl/mshr_back.sv]
module mshr_back import mshr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  job_t job_i,
  input  logic [15:0] lat_i,
  input  logic [Entries-1:0] live_i,
  input  logic [Slots-1:0] slive_i,
  output logic pop_o,
  output logic [Entries-1:0] valid_o,
  output logic [TagWidth-1:0] tag_o [Entries],
  output logic [SetWidth-1:0] set_o [Entries],
  output logic done_o,
  output out_t res_o
);
  logic [Entries-1:0] valid_q, issued_q, ret_q;
  logic [47:0] addr_q [Entries];
  logic [TagWidth-1:0] tag_q [Entries];
  logic [SetWidth-1:0] set_q [Entries];
  logic [15:0] wait_q [Entries];
  logic [SW:0] last_q [Entries];
  logic [Slots-1:0] sv_q [Entries];
  logic [1:0] kind_q [Entries][Slots];
  logic [15:0] rid_q [Entries][Slots];
  logic done_q;
  out_t res_q, r;

  logic [EW-1:0] free_idx, iss_idx;
  logic free_any, iss_any, fs_any, rp_any, rok;
  logic [SW-1:0] fs_idx, rp_idx;
  logic [EW-1:0] e, s;
  logic [Slots-1:0] sv_e, sv_s;
  logic [SW:0] nxt;
  logic [15:0] winc [Entries];

  assign pop_o = !empty_i;
  assign valid_o = valid_q;
  assign tag_o = tag_q;
  assign set_o = set_q;
  assign done_o = done_q;
  assign res_o = res_q;
  assign e = job_i.hit_idx;
  assign s = job_i.sel[EW-1:0];
  assign sv_e = sv_q[e];
  assign sv_s = sv_q[s];
  assign nxt = last_q[s] + 1'b1;
  assign rok = live_i[s] && valid_q[s] && ret_q[s];

  always_comb begin
    free_any = 1'b0; free_idx = '0; iss_any = 1'b0; iss_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (live_i[i] && !valid_q[i]) begin
        free_any = 1'b1; free_idx = EW'(i);
      end
      if (live_i[i] && valid_q[i] && !issued_q[i]) begin
        iss_any = 1'b1; iss_idx = EW'(i);
      end
    end
    fs_any = 1'b0; fs_idx = '0; rp_any = 1'b0; rp_idx = '0;
    for (int j = Slots - 1; j >= 0; j--) begin
      if (slive_i[j] && !sv_e[j]) begin
        fs_any = 1'b1; fs_idx = SW'(j);
      end
      if (sv_s[j]) begin
        rp_any = 1'b1; rp_idx = SW'(j);
      end
    end
    if (nxt < (SW+1)'(Slots) && sv_s[nxt[SW-1:0]]) begin
      rp_idx = nxt[SW-1:0];
    end
    for (int i = 0; i < Entries; i++) begin
      winc[i] = wait_q[i] + 16'd1;
    end
  end

  always_comb begin
    r = '0;
    r.status = StNothing;
    unique case (job_i.cmd)
      CmdRequest: begin
        if (job_i.hit) begin
          r.entry_index = 3'(e);
          r.status = fs_any ? StMerged : StSlotsFull;
          r.slot_index = fs_any ? 2'(fs_idx) : 2'd0;
        end else begin
          r.status = free_any ? StAlloc : StTableFull;
          r.entry_index = free_any ? 3'(free_idx) : 3'd0;
        end
      end
      CmdIssue: begin
        if (iss_any) begin
          r.status = StDone;
          r.entry_index = 3'(iss_idx);
          r.issue_addr = addr_q[iss_idx];
        end
      end
      CmdTick: r.status = StDone;
      CmdRetire: begin
        if (rok && rp_any) begin
          r.status = StDone;
          r.entry_index = job_i.sel;
          r.slot_index = 2'(rp_idx);
          r.retired_kind = kind_q[s][rp_idx];
          r.retired_id = rid_q[s][rp_idx];
          r.entry_freed = (sv_s & ~(Slots'(1) << rp_idx)) == '0;
        end
      end
      CmdLookup: begin
        if (job_i.hit) begin
          r.status = StDone;
          r.entry_index = 3'(e);
          r.lookup_hit = 1'b1;
        end
      end
      default: r.status = StNothing;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; issued_q <= '0; ret_q <= '0; done_q <= 1'b0;
      for (int i = 0; i < Entries; i++) begin
        wait_q[i] <= '0; last_q[i] <= (SW+1)'(Slots); sv_q[i] <= '0;
      end
    end else begin
      done_q <= !empty_i;
      if (!empty_i) begin
        unique case (job_i.cmd)
          CmdRequest: begin
            if (job_i.hit) begin
              if (fs_any) begin
                sv_q[e][fs_idx] <= 1'b1;
              end
            end else if (free_any) begin
              valid_q[free_idx] <= 1'b1;
              issued_q[free_idx] <= 1'b0;
              ret_q[free_idx] <= 1'b0;
              wait_q[free_idx] <= '0;
              sv_q[free_idx][0] <= 1'b1;
            end
          end
          CmdIssue: begin
            if (iss_any) begin
              issued_q[iss_idx] <= 1'b1;
            end
          end
          CmdTick: begin
            for (int i = 0; i < Entries; i++) begin
              if (live_i[i] && valid_q[i] && issued_q[i]) begin
                if (winc[i] == lat_i) begin
                  wait_q[i] <= '0; ret_q[i] <= 1'b1;
                end else begin
                  wait_q[i] <= winc[i];
                end
              end
            end
          end
          CmdRetire: begin
            if (rok && rp_any) begin
              sv_q[s][rp_idx] <= 1'b0;
              last_q[s] <= {1'b0, rp_idx};
              if (r.entry_freed) begin
                valid_q[s] <= 1'b0; issued_q[s] <= 1'b0; ret_q[s] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!empty_i) begin
      res_q <= r;
      if (job_i.cmd == CmdRequest) begin
        if (job_i.hit && fs_any) begin
          kind_q[e][fs_idx] <= job_i.kind;
          rid_q[e][fs_idx] <= job_i.rid;
        end else if (!job_i.hit && free_any) begin
          addr_q[free_idx] <= job_i.miss_addr;
          tag_q[free_idx] <= job_i.tag;
          set_q[free_idx] <= job_i.set;
          kind_q[free_idx][0] <= job_i.kind;
          rid_q[free_idx][0] <= job_i.rid;
        end
      end
    end
  end
endmodule

[rtl/mshr_table_with_merge_queues_unit.sv]
// One command is taken when start_i is high and busy_o low; its single result
// appears on result_o with done_o high for one cycle. A command is registered,
// then matched by tag and set against all entries and handed over a queue that
// reports full once it holds one beat, then applied in the table update.
// busy_o stays high until the back end has drained the queue, so a new command is
// taken only after the previous one has left the queue. The receiver cannot stall results.
module mshr_table_with_merge_queues_unit import mshr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t in_i,
  output logic busy_o,
  output logic done_o,
  output out_t result_o,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  logic [15:0] lat_q;
  logic [3:0] ent_q;
  logic [2:0] slt_q;
  logic [Entries-1:0] live, valid;
  logic [Slots-1:0] slive;
  logic [TagWidth-1:0] tags [Entries];
  logic [SetWidth-1:0] sets [Entries];
  logic push, pop, empty, full;
  job_t jin, jout;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      live[i] = (i == 0) || (5'(i) < {1'b0, ent_q});
    end
    for (int j = 0; j < Slots; j++) begin
      slive[j] = (j == 0) || (4'(j) < {1'b0, slt_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= 16'd100; ent_q <= 4'd8; slt_q <= 3'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLatency: lat_q <= cfg_data_i;
        RegEntries: ent_q <= cfg_data_i[3:0];
        RegSlots: slt_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  mshr_front u_front (.clk_i, .rst_ni, .start_i, .in_i, .valid_i(valid), .live_i(live),
    .tag_i(tags), .set_i(sets), .q_full_i(full), .busy_o, .push_o(push), .job_o(jin));

  mshr_queue u_queue (.clk_i, .rst_ni, .push_i(push), .data_i(jin), .pop_i(pop),
    .empty_o(empty), .full_o(full), .data_o(jout));

  mshr_back u_back (.clk_i, .rst_ni, .empty_i(empty), .job_i(jout), .lat_i(lat_q),
    .live_i(live), .slive_i(slive), .pop_o(pop), .valid_o(valid), .tag_o(tags),
    .set_o(sets), .done_o, .res_o(result_o));
endmodule

[rtl/mshr_checker.sv]
`include "mshr_table_with_merge_queues_unit_assert.svh"
module mshr_checker import mshr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input out_t result_o
);
  `MSHR_ASSERT_NEXT(a_busy_after_accept, start_i && !busy_o, busy_o)
  `MSHR_ASSERT_NEXT(a_no_double_done, done_o, !done_o)
  `MSHR_ASSERT_IMP(a_freed_is_done, done_o && result_o.entry_freed, result_o.status == StDone)
  `MSHR_ASSERT_IMP(a_hit_is_done, done_o && result_o.lookup_hit, result_o.status == StDone)
endmodule

bind mshr_table_with_merge_queues_unit mshr_checker u_chk (.clk_i, .rst_ni, .start_i,
  .busy_o, .done_o, .result_o);

[tb/tb_top.sv]
`timescale 1ns / 1ps

import mshr_pkg::*;

class mshr_scoreboard;
  out_t pending_q[$];
  int unsigned mismatches;
  int unsigned beats_checked;

  function void note_command(out_t predicted);
    pending_q.push_back(predicted);
  endfunction

  function void check_result(out_t got);
    out_t want;
    beats_checked++;
    if (pending_q.size() == 0) begin
      report("unexpected beat", 48'(got.status), '0);
      return;
    end
    want = pending_q.pop_front();
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.entry_index !== want.entry_index)
      report("entry_index", got.entry_index, want.entry_index);
    if (got.slot_index !== want.slot_index) report("slot_index", got.slot_index, want.slot_index);
    if (got.issue_addr !== want.issue_addr) report("issue_addr", got.issue_addr, want.issue_addr);
    if (got.retired_kind !== want.retired_kind)
      report("retired_kind", got.retired_kind, want.retired_kind);
    if (got.retired_id !== want.retired_id) report("retired_id", got.retired_id, want.retired_id);
    if (got.entry_freed !== want.entry_freed)
      report("entry_freed", got.entry_freed, want.entry_freed);
    if (got.lookup_hit !== want.lookup_hit) report("lookup_hit", got.lookup_hit, want.lookup_hit);
  endfunction

  function void report(string field, logic [47:0] got, logic [47:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("ERROR: beat %0d field %s got 0x%0h want 0x%0h", beats_checked, field, got, want);
  endfunction
endclass

module tb_top;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_t in_i;
  logic busy_o;
  logic done_o;
  out_t result_o;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [15:0] cfg_data_i;

  mshr_table_with_merge_queues_unit DUT (.*);

  mshr_scoreboard board;

  logic [15:0] lat_reg;
  logic [3:0] ent_reg;
  logic [2:0] slot_reg;
  logic vld_q[Entries];
  logic iss_q[Entries];
  logic ret_q[Entries];
  logic [47:0] addr_q[Entries];
  logic [19:0] tag_q[Entries];
  logic [11:0] set_q[Entries];
  logic [15:0] wait_q[Entries];
  int unsigned last_q[Entries];
  int unsigned used_q[Entries];
  logic sv_q[Entries][Slots];
  logic [1:0] sk_q[Entries][Slots];
  logic [15:0] sr_q[Entries][Slots];

  int unsigned idle_cycles;
  int unsigned accepted;
  int unsigned results_seen;
  int unsigned retires_done;
  int unsigned burst_left;
  bit timed_out;
  bit sampled_done;
  out_t sampled_result;

  function automatic int unsigned active_entries();
    if (ent_reg < 1) return 1;
    if (ent_reg > Entries) return Entries;
    return ent_reg;
  endfunction

  function automatic int unsigned active_slots();
    if (slot_reg < 1) return 1;
    if (slot_reg > Slots) return Slots;
    return slot_reg;
  endfunction

  function automatic int match_entry(logic [19:0] t, logic [11:0] s);
    for (int i = 0; i < active_entries(); i++)
      if (vld_q[i] && tag_q[i] == t && set_q[i] == s) return i;
    return -1;
  endfunction

  function automatic void table_reset();
    lat_reg = 16'd100;
    ent_reg = 4'd8;
    slot_reg = 3'd4;
    for (int i = 0; i < Entries; i++) begin
      vld_q[i] = 1'b0; iss_q[i] = 1'b0; ret_q[i] = 1'b0; wait_q[i] = '0;
      addr_q[i] = '0; tag_q[i] = '0; set_q[i] = '0;
      last_q[i] = Slots; used_q[i] = 0;
      for (int j = 0; j < Slots; j++) begin
        sv_q[i][j] = 1'b0; sk_q[i][j] = '0; sr_q[i][j] = '0;
      end
    end
  endfunction

  function automatic out_t predict_table(in_t c);
    out_t r;
    int m;
    int unsigned n;
    int unsigned pick;
    int unsigned nxt;
    r = '0;
    r.status = StNothing;
    n = active_entries();
    case (c.cmd)
      CmdRequest: begin
        m = match_entry(c.line_tag, c.set_number);
        if (m >= 0) begin
          r.entry_index = 3'(m);
          r.status = StSlotsFull;
          for (int j = 0; j < active_slots(); j++) begin
            if (!sv_q[m][j]) begin
              sv_q[m][j] = 1'b1; sk_q[m][j] = c.access_kind; sr_q[m][j] = c.request_id;
              used_q[m]++;
              r.status = StMerged;
              r.slot_index = 2'(j);
              break;
            end
          end
        end else begin
          r.status = StTableFull;
          for (int i = 0; i < n; i++) begin
            if (!vld_q[i]) begin
              vld_q[i] = 1'b1; iss_q[i] = 1'b0; ret_q[i] = 1'b0; wait_q[i] = '0;
              addr_q[i] = c.miss_addr; tag_q[i] = c.line_tag; set_q[i] = c.set_number;
              sv_q[i][0] = 1'b1; sk_q[i][0] = c.access_kind; sr_q[i][0] = c.request_id;
              used_q[i]++;
              r.status = StAlloc;
              r.entry_index = 3'(i);
              break;
            end
          end
        end
      end
      CmdIssue: begin
        for (int i = 0; i < n; i++) begin
          if (vld_q[i] && !iss_q[i]) begin
            iss_q[i] = 1'b1;
            r.status = StDone;
            r.entry_index = 3'(i);
            r.issue_addr = addr_q[i];
            break;
          end
        end
      end
      CmdTick: begin
        for (int i = 0; i < n; i++) begin
          if (vld_q[i] && iss_q[i]) begin
            wait_q[i] = wait_q[i] + 16'd1;
            if (wait_q[i] == lat_reg) begin
              wait_q[i] = '0;
              ret_q[i] = 1'b1;
            end
          end
        end
        r.status = StDone;
      end
      CmdRetire: begin
        if (c.entry_select < n && vld_q[c.entry_select] && ret_q[c.entry_select]) begin
          pick = Slots;
          nxt = last_q[c.entry_select] + 1;
          if (last_q[c.entry_select] < Slots && nxt < Slots && sv_q[c.entry_select][nxt])
            pick = nxt;
          for (int j = 0; pick == Slots && j < Slots; j++)
            if (sv_q[c.entry_select][j]) pick = j;
          if (pick < Slots) begin
            sv_q[c.entry_select][pick] = 1'b0;
            if (used_q[c.entry_select] > 0) used_q[c.entry_select]--;
            last_q[c.entry_select] = pick;
            r.status = StDone;
            r.entry_index = c.entry_select;
            r.slot_index = 2'(pick);
            r.retired_kind = sk_q[c.entry_select][pick];
            r.retired_id = sr_q[c.entry_select][pick];
            if (used_q[c.entry_select] == 0) begin
              vld_q[c.entry_select] = 1'b0; iss_q[c.entry_select] = 1'b0;
              ret_q[c.entry_select] = 1'b0;
              r.entry_freed = 1'b1;
            end
          end
        end
      end
      CmdLookup: begin
        m = match_entry(c.line_tag, c.set_number);
        if (m >= 0) begin
          r.status = StDone;
          r.entry_index = 3'(m);
          r.lookup_hit = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    sampled_done = done_o;
    sampled_result = result_o;
    if (rst_ni && sampled_done) begin
      board.check_result(sampled_result);
      results_seen++;
      if (sampled_result.entry_freed) retires_done++;
    end
    if (rst_ni && ((start_i && !busy_o) || sampled_done)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1;
      $display("ERROR: watchdog expired, %0d beats pending", board.pending_q.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegLatency: lat_reg = val;
      RegEntries: ent_reg = val[3:0];
      RegSlots: slot_reg = val[2:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic send_beat(in_t c);
    bit taken;
    if (burst_left == 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    in_i <= c;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy_o) begin
        taken = 1;
        board.note_command(predict_table(c));
        accepted++;
      end else begin
        @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    start_i <= 1'b0;
    burst_left = 0;
  endtask

  function automatic in_t build_cmd(logic [2:0] op, logic [19:0] t, logic [11:0] s);
    in_t c;
    c.cmd = op;
    c.miss_addr = 48'({$urandom(), $urandom()});
    c.line_tag = t;
    c.set_number = s;
    c.access_kind = 2'($urandom_range(0, 3));
    c.request_id = 16'($urandom());
    c.entry_select = 3'($urandom_range(0, 7));
    return c;
  endfunction

  task automatic random_phase(int unsigned count);
    in_t c;
    int unsigned pick;
    logic [19:0] tags[4];
    logic [11:0] sets[4];
    for (int k = 0; k < 4; k++) begin
      tags[k] = (k == 0) ? 20'hFFFFF : 20'($urandom());
      sets[k] = (k == 1) ? 12'h000 : 12'($urandom());
    end
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) c = build_cmd(CmdRequest, tags[$urandom_range(0, 3)],
                                   sets[$urandom_range(0, 3)]);
      else if (pick < 35) c = build_cmd(CmdRequest, 20'($urandom()), 12'($urandom()));
      else if (pick < 45) c = build_cmd(CmdIssue, 20'($urandom()), 12'($urandom()));
      else if (pick < 65) c = build_cmd(CmdTick, 20'($urandom()), 12'($urandom()));
      else if (pick < 87) c = build_cmd(CmdRetire, 20'($urandom()), 12'($urandom()));
      else if (pick < 95) c = build_cmd(CmdLookup, tags[$urandom_range(0, 3)],
                                        sets[$urandom_range(0, 3)]);
      else c = build_cmd(3'($urandom_range(5, 7)), 20'($urandom()), 12'($urandom()));
      send_beat(c);
    end
    stop_sending();
    drain();
  endtask

  initial begin
    in_t c;
    board = new();
    table_reset();
    start_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegLatency;
    cfg_data_i = '0;
    burst_left = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(RegLatency, 16'd1);
    // Fill the table, merge into one entry, and try beyond the limits.
    for (int i = 0; i < 9; i++) begin
      c = build_cmd(CmdRequest, 20'(i), 12'(i));
      if (i == 0) begin
        c.miss_addr = '1; c.request_id = 16'hFFFF; c.access_kind = 2'd2;
      end
      send_beat(c);
    end
    for (int i = 0; i < 4; i++) send_beat(build_cmd(CmdRequest, '0, '0));
    send_beat(build_cmd(CmdLookup, 20'd3, 12'd3));
    send_beat(build_cmd(CmdLookup, 20'hFFFFF, 12'hFFF));
    for (int i = 0; i < 3; i++) send_beat(build_cmd(CmdIssue, '0, '0));
    send_beat(build_cmd(CmdTick, '0, '0));
    for (int i = 0; i < 5; i++) begin
      c = build_cmd(CmdRetire, '0, '0);
      c.entry_select = 3'd0;
      send_beat(c);
    end
    send_beat(build_cmd(3'd7, '0, '0));
    stop_sending();
    drain();

    random_phase(300);
    write_reg(RegLatency, 16'd3);
    write_reg(RegEntries, 16'd2);
    write_reg(RegSlots, 16'd1);
    random_phase(250);
    write_reg(RegEntries, 16'd0);
    write_reg(RegSlots, 16'd7);
    write_reg(RegLatency, 16'd2);
    random_phase(200);
    write_reg(RegEntries, 16'd15);
    write_reg(RegSlots, 16'd0);
    write_reg(RegLatency, 16'hFFFF);
    random_phase(100);
    write_reg(RegEntries, 16'd8);
    write_reg(RegSlots, 16'd4);
    write_reg(RegLatency, 16'd5);
    random_phase(280);

    $display("Ran %0d commands, checked %0d results, %0d entries freed by retire.",
             accepted, results_seen, retires_done);
    $display("Register settings covered latency 1 to 65535, 0 to 15 entries, 0 to 7 slots.");
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/mshr_pkg.sv
rtl/mshr_front.sv
rtl/mshr_queue.sv
rtl/mshr_back.sv
rtl/mshr_table_with_merge_queues_unit.sv
rtl/mshr_checker.sv
tb/tb_top.sv
